// ===== hdl/ltdc_pkg.sv =====
// Package for the light tracker direction controller.
// Holds shared types, register indexes, reset values and code constants.
// No dependencies.
package ltdc_pkg;

    localparam int DARK_W = 10;
    localparam int TOL_W  = 10;
    localparam int HEAT_W = 9;
    localparam int CFG_W  = 10;
    localparam int IDX_W  = 2;
    localparam int REQ_W  = 2;
    localparam int EV_W   = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_DARKNESS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [IDX_W-1:0] CFG_HEAT      = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MONITOR   = 2'd3;

    // reset values of the configuration registers
    localparam logic [DARK_W-1:0] DARK_RST = 10'd100;
    localparam logic [TOL_W-1:0]  TOL_RST  = 10'd100;
    localparam logic [HEAT_W-1:0] HEAT_RST = 9'd50;
    localparam logic              MON_RST  = 1'b1;

    // standby request codes
    localparam logic [REQ_W-1:0] REQ_LEAVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ENTER = 2'd2;

    typedef enum logic [1:0] {
        DIR_STOPPED = 2'd0,
        DIR_LEFT    = 2'd1,
        DIR_RIGHT   = 2'd2
    } t_dir;

    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 3'd0,
        EV_STOPPED  = 3'd1,
        EV_LEFT     = 3'd2,
        EV_RIGHT    = 3'd3,
        EV_NIGHT    = 3'd4,
        EV_STANDBY  = 3'd5,
        EV_OVERHEAT = 3'd6
    } t_event;

    typedef struct packed {
        logic [DARK_W-1:0] darkness_level;
        logic [TOL_W-1:0]  balance_tolerance;
        logic [HEAT_W-1:0] heat_limit;
        logic              monitor_enable;
    } t_cfg;

    typedef struct packed {
        logic   drive_left;
        logic   drive_right;
        logic   standby_lamp;
        logic   cooling_lamp;
        t_event event_res;
    } t_result;

endpackage

// ===== hdl/ltdc_cfg.sv =====
// Configuration registers of the light tracker direction controller.
// Depends on ltdc_pkg.
module ltdc_cfg import ltdc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.darkness_level    <= DARK_RST;
            r_cfg.balance_tolerance <= TOL_RST;
            r_cfg.heat_limit        <= HEAT_RST;
            r_cfg.monitor_enable    <= MON_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DARKNESS:  r_cfg.darkness_level    <= i_cfg_data[DARK_W-1:0];
                CFG_TOLERANCE: r_cfg.balance_tolerance <= i_cfg_data[TOL_W-1:0];
                CFG_HEAT:      r_cfg.heat_limit        <= i_cfg_data[HEAT_W-1:0];
                CFG_MONITOR:   r_cfg.monitor_enable    <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/ltdc_core.sv =====
// Decision logic and tracker state of the light tracker direction controller.
// Depends on ltdc_pkg.
module ltdc_core import ltdc_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  t_cfg                   i_cfg,
    input  logic [SAMPLE_BITS-1:0] i_sample_first,
    input  logic [SAMPLE_BITS-1:0] i_sample_second,
    input  logic [SAMPLE_BITS-1:0] i_heat_sample,
    input  logic [REQ_W-1:0]       i_standby_request,
    input  logic                   i_toggle_standby,
    output t_result                o_res
);

    localparam int CMP_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;

    t_dir r_dir,      n_dir;
    logic r_standby,  n_standby;
    logic r_left,     n_left;
    logic r_right,    n_right;

    logic [CMP_W-1:0] s1, s2, heat, dark, tol, heat_max, diff;
    logic             sb, hot, moving, bright;
    t_event           ev;

    always_comb begin
        s1       = CMP_W'(i_sample_first);
        s2       = CMP_W'(i_sample_second);
        heat     = CMP_W'(i_heat_sample);
        dark     = CMP_W'(i_cfg.darkness_level);
        tol      = CMP_W'(i_cfg.balance_tolerance);
        heat_max = CMP_W'({i_cfg.heat_limit, 1'b0});
        diff     = (s1 > s2) ? (s1 - s2) : (s2 - s1);

        sb = r_standby;
        if (i_standby_request == REQ_LEAVE) begin
            sb = 1'b0;
        end else if (i_standby_request == REQ_ENTER) begin
            sb = 1'b1;
        end
        sb = sb ^ i_toggle_standby;

        hot    = heat > heat_max;
        moving = i_cfg.monitor_enable && (r_dir == DIR_LEFT || r_dir == DIR_RIGHT);
        bright = (s1 > dark) || (s2 > dark);

        n_dir     = r_dir;
        n_left    = r_left;
        n_right   = r_right;
        n_standby = sb | hot;
        ev        = EV_NONE;

        if (!sb && !hot) begin
            if (bright) begin
                if (diff < tol) begin
                    n_left  = 1'b0;
                    n_right = 1'b0;
                    if (moving) begin
                        n_dir = DIR_STOPPED;
                        ev    = EV_STOPPED;
                    end
                end else if (s1 > s2) begin
                    n_left  = 1'b1;
                    n_right = 1'b0;
                    if (i_cfg.monitor_enable && r_dir != DIR_LEFT) begin
                        n_dir = DIR_LEFT;
                        ev    = EV_LEFT;
                    end
                end else if (s1 < s2) begin
                    n_left  = 1'b0;
                    n_right = 1'b1;
                    if (i_cfg.monitor_enable && r_dir != DIR_RIGHT) begin
                        n_dir = DIR_RIGHT;
                        ev    = EV_RIGHT;
                    end
                end
                // exact tie with zero tolerance: keep drive and direction, no event
            end else begin
                n_left  = 1'b0;
                n_right = 1'b0;
                if (moving) begin
                    n_dir = DIR_STOPPED;
                    ev    = EV_NIGHT;
                end
            end
        end else begin
            n_left  = 1'b0;
            n_right = 1'b0;
            // standby wins over overheat in the event code when a moving direction is stopped
            if (moving) begin
                n_dir = DIR_STOPPED;
                ev    = sb ? EV_STANDBY : EV_OVERHEAT;
            end
        end

        o_res.drive_left   = n_left;
        o_res.drive_right  = n_right;
        o_res.standby_lamp = sb;
        o_res.cooling_lamp = hot;
        o_res.event_res    = ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= DIR_STOPPED;
            r_standby <= 1'b0;
            r_left    <= 1'b0;
            r_right   <= 1'b0;
        end else if (i_adv) begin
            r_dir     <= n_dir;
            r_standby <= n_standby;
            r_left    <= n_left;
            r_right   <= n_right;
        end
    end

endmodule

// ===== hdl/light_tracker_direction_control.sv =====
// Top level of the light tracker direction controller.
// Depends on ltdc_pkg, ltdc_cfg and ltdc_core.
//
// Sun-tracker motor controller. Each request carries two light samples, a
// heat sample and standby controls, and yields exactly one result: two motor
// drive lines, standby and cooling lamps and an event code. A request passes
// through an input register, one level of compare logic and a result
// register; the result register takes the result once the result slot is
// free. A new request is taken in every cycle while the input side does not
// stall; throughput is one request per cycle while the result channel is
// not stalled, set by the compare path and the tracker state it updates. The
// result register holds a stalled result while the input register takes the
// next request, and the input side stalls only when both registers are full.
// Configuration registers (0 darkness level, 1 balance tolerance, 2 heat
// limit, 3 monitor enable) are written through i_cfg_we and must only change
// while no request is in flight.
module light_tracker_direction_control import ltdc_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample_first,
    input  logic [SAMPLE_BITS-1:0] i_sample_second,
    input  logic [SAMPLE_BITS-1:0] i_heat_sample,
    input  logic [REQ_W-1:0]       i_standby_request,
    input  logic                   i_toggle_standby,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_drive_left,
    output logic                   o_drive_right,
    output logic                   o_standby_lamp,
    output logic                   o_cooling_lamp,
    output logic [EV_W-1:0]        o_event_res
);

    t_cfg    cfg;
    t_result res;

    logic                   r_in_vld;
    logic [SAMPLE_BITS-1:0] r_s1, r_s2, r_heat;
    logic [REQ_W-1:0]       r_req;
    logic                   r_tog;

    logic                   r_out_vld;
    t_result                r_res;

    logic adv;
    logic in_take;

    // advance the request in the input register when the result slot frees up
    assign adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_take  = i_in_valid && !o_in_stall;

    ltdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ltdc_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (adv),
        .i_cfg             (cfg),
        .i_sample_first    (r_s1),
        .i_sample_second   (r_s2),
        .i_heat_sample     (r_heat),
        .i_standby_request (r_req),
        .i_toggle_standby  (r_tog),
        .o_res             (res)
    );

    // input register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // input register: payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1   <= i_sample_first;
            r_s2   <= i_sample_second;
            r_heat <= i_heat_sample;
            r_req  <= i_standby_request;
            r_tog  <= i_toggle_standby;
        end
    end

    // result register: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // result register: payload, hold while stalled
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_drive_left   = r_res.drive_left;
    assign o_drive_right  = r_res.drive_right;
    assign o_standby_lamp = r_res.standby_lamp;
    assign o_cooling_lamp = r_res.cooling_lamp;
    assign o_event_res    = r_res.event_res;

endmodule
